>>> sv/olst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types, codes and sizing for the ordered list engine.
// ----------------------------------------------------------------------------
package olst_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_INSERT_AT  = 3'd2;
   localparam logic [2:0] ACT_DELETE     = 3'd3;
   localparam logic [2:0] ACT_SEARCH     = 3'd4;
   localparam logic [2:0] ACT_READ_OUT   = 3'd5;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NEG_POS   = 3'd4;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] item_value;
      logic signed [15:0] insert_position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         found_index;
      logic signed [31:0] element_value;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_DRAIN,
      S_PLACE,
      S_SCAN,
      S_READ_ISSUE,
      S_READ_DATA,
      S_RESPOND
   } state_type;

   function automatic logic [DATA_WIDTH-1:0] to_word(input logic [31:0] v);
      logic signed [63:0] t;
      t = 64'($signed(v));
      return t[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] word_to_out(input logic [DATA_WIDTH-1:0] w);
      logic signed [63:0] t;
      t = 64'($signed(w));
      return t[31:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/olst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module olst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> sv/ordered_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed words kept in one element RAM, with insert, delete,
// search and read-out requests.
// ----------------------------------------------------------------------------
// One request at a time. Refused requests go straight to the response. Insert moves
// each element behind the target one slot toward the back, then places the new word;
// a push at the back moves nothing. Search scans the elements from the front; delete
// then moves each element behind the match one slot toward the front. Read-out reads
// the elements one by one from the front, all through the single read port of the RAM.
// Reset clears the state, the element count and the valid flags; the RAM is never cleared.
module ordered_list_engine
   import olst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      walk_ff, walk_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [2:0]            act_ff, act_in;
   logic [31:0]           echo_ff, echo_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [2:0]            status_ff, status_in;
   logic [IDX_W-1:0]      fidx_ff, fidx_in;
   logic                  mv_valid_ff, mv_valid_in;
   logic [IDX_W-1:0]      mv_dst_ff, mv_dst_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  slot_free;
   logic                  is_insert;
   logic                  neg_pos;
   logic                  full;
   logic                  empty;
   logic [CNT_W-1:0]      target;
   logic [CNT_W-1:0]      count_m1;
   logic                  match;
   logic                  scan_last;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_insert = req_data.action inside {ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT};
   assign neg_pos   = (req_data.action == ACT_INSERT_AT) && req_data.insert_position[15];
   assign full      = (32'(count_ff) == 32'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign count_m1  = count_ff - CNT_W'(1);
   assign match     = cmp_valid_ff && (rd_data == word_ff);
   assign scan_last = cmp_valid_ff && (CNT_W'(cmp_idx_ff) == count_m1);

   always_comb begin
      case (req_data.action)
         ACT_PUSH_FRONT: target = '0;
         ACT_PUSH_BACK:  target = count_ff;
         default: begin
            if (32'(req_data.insert_position[14:0]) > 32'(count_ff)) begin
               target = count_ff;
            end else begin
               target = CNT_W'(req_data.insert_position[14:0]);
            end
         end
      endcase
   end

   // element store
   assign wr_en   = mv_valid_ff || (state_ff == S_PLACE);
   assign wr_addr = (state_ff == S_PLACE) ? pos_ff[IDX_W-1:0] : mv_dst_ff;
   assign wr_data = (state_ff == S_PLACE) ? word_ff : rd_data;

   olst_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (walk_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_insert) begin
                  if (neg_pos || full) begin
                     state_in = S_RESPOND;
                  end else if (target == count_ff) begin
                     state_in = S_PLACE;
                  end else begin
                     state_in = S_SHIFT_UP;
                  end
               end else if (req_data.action inside {ACT_DELETE, ACT_SEARCH}) begin
                  state_in = empty ? S_RESPOND : S_SCAN;
               end else if (req_data.action == ACT_READ_OUT) begin
                  state_in = empty ? S_RESPOND : S_READ_ISSUE;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_SHIFT_UP: begin
            if (walk_ff == pos_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_SHIFT_DOWN: begin
            if (walk_ff == count_m1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = (act_ff == ACT_DELETE) ? S_RESPOND : S_PLACE;
         end
         S_PLACE: begin
            state_in = S_RESPOND;
         end
         S_SCAN: begin
            if (match) begin
               if (act_ff == ACT_SEARCH || scan_last) begin
                  state_in = S_RESPOND;
               end else begin
                  state_in = S_SHIFT_DOWN;
               end
            end else if (scan_last) begin
               state_in = S_RESPOND;
            end
         end
         S_READ_ISSUE: begin
            if (slot_free) begin
               state_in = S_READ_DATA;
            end
         end
         S_READ_DATA: begin
            state_in = (walk_ff == count_m1) ? S_IDLE : S_READ_ISSUE;
         end
         S_RESPOND: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_in     = count_ff;
      walk_in      = walk_ff;
      pos_in       = pos_ff;
      act_in       = act_ff;
      echo_in      = echo_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      fidx_in      = fidx_ff;
      mv_valid_in  = 1'b0;
      mv_dst_in    = mv_dst_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in    = req_data.action;
               echo_in   = req_data.item_value;
               word_in   = to_word(req_data.item_value);
               pos_in    = target;
               fidx_in   = '0;
               walk_in   = is_insert ? count_m1 : '0;
               status_in = ST_DONE;
               if (neg_pos) begin
                  status_in = ST_NEG_POS;
               end else if (is_insert && full) begin
                  status_in = ST_FULL;
               end else if (empty && (req_data.action inside
                            {ACT_DELETE, ACT_SEARCH, ACT_READ_OUT})) begin
                  status_in = ST_EMPTY;
               end
            end
         end
         S_SHIFT_UP: begin
            mv_valid_in = 1'b1;
            mv_dst_in   = IDX_W'(walk_ff + CNT_W'(1));
            walk_in     = walk_ff - CNT_W'(1);
         end
         S_SHIFT_DOWN: begin
            mv_valid_in = 1'b1;
            mv_dst_in   = IDX_W'(walk_ff - CNT_W'(1));
            walk_in     = walk_ff + CNT_W'(1);
         end
         S_DRAIN: begin
            if (act_ff == ACT_DELETE) begin
               count_in = count_m1;
            end
         end
         S_PLACE: begin
            count_in = count_ff + CNT_W'(1);
         end
         S_SCAN: begin
            if (walk_ff < count_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = walk_ff[IDX_W-1:0];
               walk_in      = walk_ff + CNT_W'(1);
            end
            if (match) begin
               cmp_valid_in = 1'b0;
               if (act_ff == ACT_SEARCH) begin
                  fidx_in = cmp_idx_ff;
               end else if (scan_last) begin
                  count_in = count_m1;
               end else begin
                  walk_in = CNT_W'(cmp_idx_ff) + CNT_W'(1);
               end
            end else if (scan_last) begin
               status_in = ST_NOT_FOUND;
            end
         end
         S_READ_DATA: begin
            rsp_in.status        = ST_DONE;
            rsp_in.found_index   = '0;
            rsp_in.element_value = word_to_out(rd_data);
            rsp_in.last          = (walk_ff == count_m1);
            rsp_valid_in         = 1'b1;
            walk_in              = walk_ff + CNT_W'(1);
         end
         S_RESPOND: begin
            if (slot_free) begin
               rsp_in.status        = status_ff;
               rsp_in.found_index   = 6'(fidx_ff);
               rsp_in.element_value = echo_ff;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mv_valid_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mv_valid_ff  <= mv_valid_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff    <= walk_in;
      pos_ff     <= pos_in;
      act_ff     <= act_in;
      echo_ff    <= echo_in;
      word_ff    <= word_in;
      status_ff  <= status_in;
      fidx_ff    <= fidx_in;
      mv_dst_ff  <= mv_dst_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("element count above capacity");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SHIFT_UP || state_ff == S_SHIFT_DOWN ||
                 state_ff == S_DRAIN || state_ff == S_PLACE))
      else $error("store written outside a move or place step");

   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ_DATA) |-> !rsp_valid_ff)
      else $error("read-out data arrived with result slot occupied");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> (state_ff == S_RESPOND))
      else $error("element count changed outside request completion");

endmodule
`default_nettype wire
